// ===== rtl/core/itf_pkg.sv =====
// ----------------------------------------------------------------------------
// itf_pkg: shared types and constants of the tilt filter
// Register indexes, reset values, CORDIC word layout and arctangent table.
// ----------------------------------------------------------------------------
package itf_pkg;

  // CORDIC datapath widths
  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned XY_W         = 34;
  localparam int unsigned Z_W          = 30;
  localparam int unsigned ANG_W        = 22;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_GATE_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE_HIGH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_DIVISOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_WEIGHT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TAKE_WEIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RAD_TO_DEG   = 3'd6;

  // register reset values
  localparam logic [23:0] RST_GATE_LOW     = 24'd1411510;
  localparam logic [23:0] RST_GATE_HIGH    = 24'd4705028;
  localparam logic [15:0] RST_GYRO_DIVISOR = 16'd131;
  localparam logic [15:0] RST_SAMPLE_PER   = 16'd655;
  localparam logic [16:0] RST_KEEP_WEIGHT  = 17'd64225;
  localparam logic [16:0] RST_TAKE_WEIGHT  = 17'd1311;
  localparam logic [22:0] RST_RAD_TO_DEG   = 23'd3756841;

  // pi in Q24 radians
  localparam logic signed [Z_W-1:0] PI_Q24 = 30'sd52707179;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_MULG,
    ST_INTEG,
    ST_BLEND,
    ST_SUM
  } state_e;

  // word handed from cell to cell
  typedef struct packed {
    logic                    valid;
    logic                    zero;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
  } cordic_t;

  // arctangent of 2^-i in Q24 radians
  function automatic logic signed [Z_W-1:0] atan_q24(input int unsigned i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:       v = 30'sd13176795;
      1:       v = 30'sd7778716;
      2:       v = 30'sd4110060;
      3:       v = 30'sd2086331;
      4:       v = 30'sd1047214;
      5:       v = 30'sd524117;
      6:       v = 30'sd262123;
      7:       v = 30'sd131069;
      8:       v = 30'sd65536;
      9:       v = 30'sd32768;
      10:      v = 30'sd16384;
      11:      v = 30'sd8192;
      12:      v = 30'sd4096;
      13:      v = 30'sd2048;
      14:      v = 30'sd1024;
      15:      v = 30'sd512;
      16:      v = 30'sd256;
      17:      v = 30'sd128;
      18:      v = 30'sd64;
      19:      v = 30'sd32;
      20:      v = 30'sd16;
      21:      v = 30'sd8;
      22:      v = 30'sd4;
      23:      v = 30'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/itf_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// itf_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates the incoming word by the fixed step angle and registers it.
// ----------------------------------------------------------------------------
module itf_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  itf_pkg::cordic_t prev_i,
  output itf_pkg::cordic_t next_o
);
  import itf_pkg::*;

  logic signed [XY_W-1:0] xs, ys;
  cordic_t                cell_d, cell_q;

  // rotate towards the x axis
  always_comb begin
    xs           = prev_i.x >>> STAGE;
    ys           = prev_i.y >>> STAGE;
    cell_d       = prev_i;
    if (!prev_i.y[XY_W-1]) begin
      cell_d.x = prev_i.x + ys;
      cell_d.y = prev_i.y - xs;
      cell_d.z = prev_i.z + atan_q24(STAGE);
    end else begin
      cell_d.x = prev_i.x - ys;
      cell_d.y = prev_i.y + xs;
      cell_d.z = prev_i.z - atan_q24(STAGE);
    end
  end

  // cell register, valid flag cleared on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign next_o = cell_q;

endmodule

// ===== rtl/core/itf_cordic_chain.sv =====
// ----------------------------------------------------------------------------
// itf_cordic_chain: atan2 as a row of CORDIC cells
// Folds the operands into the right half plane, runs them through the
// cells and rounds the angle to Q16 radians.
// ----------------------------------------------------------------------------
module itf_cordic_chain (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                launch_i,
  input  logic signed [22:0]                  y_i,
  input  logic signed [22:0]                  x_i,
  output logic                                valid_o,
  output logic signed [itf_pkg::ANG_W-1:0]    ang_o
);
  import itf_pkg::*;

  cordic_t                link [CORDIC_STEPS+1];
  logic signed [23:0]     xf, yf;
  logic signed [Z_W-1:0]  zr;

  // fold into the right half plane and scale by 2^8
  always_comb begin
    link[0].valid = launch_i;
    link[0].zero  = (x_i == '0) && (y_i == '0);
    if (x_i[22]) begin
      xf           = -{x_i[22], x_i};
      yf           = -{y_i[22], y_i};
      link[0].z    = y_i[22] ? -PI_Q24 : PI_Q24;
    end else begin
      xf           = {x_i[22], x_i};
      yf           = {y_i[22], y_i};
      link[0].z    = '0;
    end
    link[0].x = {{(XY_W-32){xf[23]}}, xf, 8'd0};
    link[0].y = {{(XY_W-32){yf[23]}}, yf, 8'd0};
  end

  // row of cells
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    itf_cordic_cell #(
      .STAGE(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .prev_i(link[g]),
      .next_o(link[g+1])
    );
  end

  // round Q24 to Q16
  always_comb begin
    zr    = (link[CORDIC_STEPS].z + Z_W'(128)) >>> 8;
    ang_o = link[CORDIC_STEPS].zero ? '0 : zr[ANG_W-1:0];
  end

  assign valid_o = link[CORDIC_STEPS].valid;

endmodule

// ===== rtl/core/itf_divider.sv =====
// ----------------------------------------------------------------------------
// itf_divider: gyro rate divider
// Restoring division of a signed rate by an unsigned divisor, one quotient
// bit a cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module itf_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [24:0] dividend_i,
  input  logic [15:0]        divisor_i,
  output logic               busy_o,
  output logic signed [25:0] quot_o
);
  import itf_pkg::*;

  logic [16:0] rem_q, rem_d;
  logic [24:0] quo_q, quo_d;
  logic [15:0] dv_q, dv_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        neg_q, neg_d;
  logic [16:0] part;

  // one restoring step per cycle
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dv_d   = dv_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    part   = {rem_q[15:0], quo_q[24]};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i[24] ? 25'(-dividend_i) : 25'(dividend_i);
      dv_d   = (divisor_i == '0) ? 16'd1 : divisor_i;
      cnt_d  = 5'd24;
      busy_d = 1'b1;
      neg_d  = dividend_i[24];
    end else if (busy_q) begin
      if (part >= {1'b0, dv_q}) begin
        rem_d = part - {1'b0, dv_q};
        quo_d = {quo_q[23:0], 1'b1};
      end else begin
        rem_d = part;
        quo_d = {quo_q[23:0], 1'b0};
      end
      cnt_d  = cnt_q - 5'd1;
      busy_d = (cnt_q != '0);
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dv_q  <= dv_d;
    neg_q <= neg_d;
  end

  assign busy_o = busy_q;
  assign quot_o = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

// ===== rtl/core/imu_complementary_tilt_filter_unit.sv =====
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter_unit: pitch and roll complementary filter
// Integrates gyro rates and, inside the magnitude gate, blends in accelerometer tilt from atan2.
// ----------------------------------------------------------------------------
// a word is taken only in the idle state, so the next word waits until the result
// is loaded; the 25-step rate dividers and the 24-cell CORDIC rows run side by side,
// then come the multiply, integrate, blend and sum steps
// reset: angles clear to zero, registers take their default values,
// no clearing pass
module imu_complementary_tilt_filter_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [itf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [itf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [22:0]              accel_x_i,
  input  logic signed [22:0]              accel_y_i,
  input  logic signed [22:0]              accel_z_i,
  input  logic signed [24:0]              gyro_x_i,
  input  logic signed [24:0]              gyro_y_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [31:0]              pitch_angle_o,
  output logic signed [31:0]              roll_angle_o,
  output logic                            corrected_o
);
  import itf_pkg::*;

  // configuration registers
  logic [23:0] gate_low_q, gate_high_q;
  logic [15:0] gyro_div_q, sample_per_q;
  logic [16:0] keep_w_q, take_w_q;
  logic [22:0] r2d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_low_q   <= RST_GATE_LOW;
      gate_high_q  <= RST_GATE_HIGH;
      gyro_div_q   <= RST_GYRO_DIVISOR;
      sample_per_q <= RST_SAMPLE_PER;
      keep_w_q     <= RST_KEEP_WEIGHT;
      take_w_q     <= RST_TAKE_WEIGHT;
      r2d_q        <= RST_RAD_TO_DEG;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GATE_LOW:     gate_low_q   <= cfg_data_i;
        CFG_GATE_HIGH:    gate_high_q  <= cfg_data_i;
        CFG_GYRO_DIVISOR: gyro_div_q   <= cfg_data_i[15:0];
        CFG_SAMPLE_PER:   sample_per_q <= cfg_data_i[15:0];
        CFG_KEEP_WEIGHT:  keep_w_q     <= cfg_data_i[16:0];
        CFG_TAKE_WEIGHT:  take_w_q     <= cfg_data_i[16:0];
        CFG_RAD_TO_DEG:   r2d_q        <= cfg_data_i[22:0];
        default: ;
      endcase
    end
  end

  // sequencer signals
  state_e state_q, state_d;
  logic   accept, run_done, out_free, load_out;
  logic   pdiv_busy, rdiv_busy, pch_valid, rch_valid, ang_ok_q;
  logic signed [25:0]      pquot, rquot;
  logic signed [ANG_W-1:0] pang, rang;

  assign accept   = in_valid_i && !in_stall_o;
  assign run_done = ang_ok_q && !pdiv_busy && !rdiv_busy;
  assign out_free = !out_valid_o || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_RUN;
      ST_RUN:   if (run_done) state_d = ST_MULG;
      ST_MULG:  state_d = ST_INTEG;
      ST_INTEG: state_d = ST_BLEND;
      ST_BLEND: state_d = ST_SUM;
      ST_SUM:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_SUM:  load_out   = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // rate dividers
  itf_divider u_pdiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .dividend_i(gyro_x_i),
    .divisor_i (gyro_div_q),
    .busy_o    (pdiv_busy),
    .quot_o    (pquot)
  );

  itf_divider u_rdiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .dividend_i(gyro_y_i),
    .divisor_i (gyro_div_q),
    .busy_o    (rdiv_busy),
    .quot_o    (rquot)
  );

  // accelerometer angles
  itf_cordic_chain u_pchain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .launch_i(accept),
    .y_i     (accel_y_i),
    .x_i     (accel_z_i),
    .valid_o (pch_valid),
    .ang_o   (pang)
  );

  itf_cordic_chain u_rchain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .launch_i(accept),
    .y_i     (accel_x_i),
    .x_i     (accel_z_i),
    .valid_o (rch_valid),
    .ang_o   (rang)
  );

  // gate on the magnitude sum
  logic [22:0] abs_x, abs_y, abs_z;
  logic [24:0] mag;
  logic        corr_q;

  always_comb begin
    abs_x = accel_x_i[22] ? 23'(-accel_x_i) : 23'(accel_x_i);
    abs_y = accel_y_i[22] ? 23'(-accel_y_i) : 23'(accel_y_i);
    abs_z = accel_z_i[22] ? 23'(-accel_z_i) : 23'(accel_z_i);
    mag   = 25'(abs_x) + 25'(abs_y) + 25'(abs_z);
  end

  // datapath registers
  logic signed [ANG_W-1:0] pang_q, rang_q;
  logic signed [26:0]      ptp_q, rtp_q;
  logic signed [27:0]      pdeg_q, rdeg_q;
  logic signed [31:0]      pint_q, rint_q;
  logic signed [33:0]      pkeep_q, rkeep_q;
  logic signed [29:0]      ptake_q, rtake_q;
  logic signed [31:0]      pitch_q, roll_q;
  logic signed [31:0]      pout_q, rout_q;
  logic                    cout_q, ovalid_q;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -35'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // products for the current step
  logic signed [42:0] ptp_full, rtp_full;
  logic signed [45:0] pdeg_full, rdeg_full;
  logic signed [49:0] pkeep_full, rkeep_full;
  logic signed [45:0] ptake_full, rtake_full;

  always_comb begin
    ptp_full   = 43'(pquot) * 43'($signed({1'b0, sample_per_q}));
    rtp_full   = 43'(rquot) * 43'($signed({1'b0, sample_per_q}));
    pdeg_full  = 46'(pang_q) * 46'($signed({1'b0, r2d_q}));
    rdeg_full  = 46'(rang_q) * 46'($signed({1'b0, r2d_q}));
    pkeep_full = 50'(pint_q) * 50'($signed({1'b0, keep_w_q}));
    rkeep_full = 50'(rint_q) * 50'($signed({1'b0, keep_w_q}));
    ptake_full = 46'(pdeg_q) * 46'($signed({1'b0, take_w_q}));
    rtake_full = 46'(rdeg_q) * 46'($signed({1'b0, take_w_q}));
  end

  // angle capture flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_ok_q <= 1'b0;
    end else if (accept) begin
      ang_ok_q <= 1'b0;
    end else if (pch_valid) begin
      ang_ok_q <= 1'b1;
    end
  end

  // per-step datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      corr_q <= (mag > 25'(gate_low_q)) && (mag < 25'(gate_high_q));
    end
    if (pch_valid) begin
      pang_q <= pang;
      rang_q <= rang;
    end
    if (state_q == ST_MULG) begin
      ptp_q  <= ptp_full[42:16];
      rtp_q  <= rtp_full[42:16];
      pdeg_q <= pdeg_full[43:16];
      rdeg_q <= rdeg_full[43:16];
    end
    if (state_q == ST_INTEG) begin
      pint_q <= sat32(35'(pitch_q) + 35'(ptp_q));
      rint_q <= sat32(35'(roll_q) - 35'(rtp_q));
    end
    if (state_q == ST_BLEND) begin
      pkeep_q <= pkeep_full[49:16];
      rkeep_q <= rkeep_full[49:16];
      ptake_q <= ptake_full[45:16];
      rtake_q <= rtake_full[45:16];
    end
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q <= '0;
      roll_q  <= '0;
    end else if (load_out) begin
      pitch_q <= corr_q ? sat32(35'(pkeep_q) + 35'(ptake_q)) : pint_q;
      roll_q  <= corr_q ? sat32(35'(rkeep_q) + 35'(rtake_q)) : rint_q;
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (load_out) begin
      ovalid_q <= 1'b1;
    end else if (!out_stall_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      pout_q <= corr_q ? sat32(35'(pkeep_q) + 35'(ptake_q)) : pint_q;
      rout_q <= corr_q ? sat32(35'(rkeep_q) + 35'(rtake_q)) : rint_q;
      cout_q <= corr_q;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign pitch_angle_o = pout_q;
  assign roll_angle_o  = rout_q;
  assign corrected_o   = cout_q;

  // both angle rows run in lock step
  a_chains_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pch_valid == rch_valid)
    else $error("angle rows out of step");

  // angles only leave the rows while a word is being worked on
  a_chain_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pch_valid |-> state_q == ST_RUN)
    else $error("angle result outside run phase");

  // quotients are settled before they are used
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MULG |-> !pdiv_busy && !rdiv_busy && ang_ok_q)
    else $error("multiply step before operands ready");

  // an accepted word always starts the run phase
  a_accept_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_RUN && pdiv_busy)
    else $error("accepted word did not start");

endmodule
